### src/list_stack_queue_with_search_unit_macros.svh
// ----------------------------------------------------------------------------
// list_stack_queue_with_search_unit_macros
// Assertion macros shared by the deque modules. They sample on clock and
// stay quiet during reset.
// ----------------------------------------------------------------------------
`ifndef LIST_STACK_QUEUE_WITH_SEARCH_UNIT_MACROS_SVH
`define LIST_STACK_QUEUE_WITH_SEARCH_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define LSQS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// consequent holds at the edge after the antecedent
`define LSQS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/lsqs_pkg.sv
// ----------------------------------------------------------------------------
// lsqs_pkg
// Types and constants shared by the deque with search.
// ----------------------------------------------------------------------------
package lsqs_pkg;

   localparam int unsigned DEPTH_DEFAULT = 64;
   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned COUNT_W       = 7;

   typedef enum logic [1:0] {
      OP_PUSH_REAR  = 2'd0,
      OP_POP_REAR   = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_SEARCH     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               found;
      stat_type           status;
   } res_type;

endpackage

### src/lsqs_ram.sv
// ----------------------------------------------------------------------------
// lsqs_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lsqs_ram #(
   parameter int unsigned DEPTH = lsqs_pkg::DEPTH_DEFAULT,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [lsqs_pkg::VALUE_W-1:0]   wr_data,
   input  logic                           rd_en,
   input  logic [AW-1:0]                  rd_addr,
   output logic [lsqs_pkg::VALUE_W-1:0]   rd_data
);
   import lsqs_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/lsqs_ctrl.sv
// ----------------------------------------------------------------------------
// lsqs_ctrl
// Sequencer: ring pointers, push and pop updates, and the search scan that
// runs one shared comparator over the held entries, one entry a cycle.
// ----------------------------------------------------------------------------
`include "list_stack_queue_with_search_unit_macros.svh"

module lsqs_ctrl #(
   parameter int unsigned DEPTH = lsqs_pkg::DEPTH_DEFAULT,
   localparam int unsigned AW   = $clog2(DEPTH),
   localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lsqs_pkg::op_type               req_op,
   input  logic [lsqs_pkg::VALUE_W-1:0]   req_value,
   output logic                           res_valid,
   input  logic                           res_ready,
   output lsqs_pkg::res_type              res,
   output logic                           mem_wr_en,
   output logic [AW-1:0]                  mem_wr_addr,
   output logic [lsqs_pkg::VALUE_W-1:0]   mem_wr_data,
   output logic                           mem_rd_en,
   output logic [AW-1:0]                  mem_rd_addr,
   input  logic [lsqs_pkg::VALUE_W-1:0]   mem_rd_data
);
   import lsqs_pkg::*;

   localparam int unsigned SW = AW + 1;
   localparam logic [CW-1:0] CntFull = CW'(DEPTH);

   state_type          state_ff, state_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   res_type            res_ff, res_in;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] count_out(input logic [CW-1:0] c);
      logic [CW+COUNT_W-1:0] ext;
      ext = {{COUNT_W{1'b0}}, c};
      return ext[COUNT_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      key_ff  <= key_in;
      res_ff  <= res_in;
   end

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      key_in      = key_ff;
      res_in      = res_ff;
      req_ready   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = slot_of(head_ff, count_ff);
      mem_wr_data = req_value;
      mem_rd_en   = 1'b0;
      mem_rd_addr = slot_of(head_ff, scan_ff);

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in        = req_value;
               scan_in       = '0;
               pend_in       = 1'b0;
               res_in.found  = 1'b0;
               res_in.status = STAT_DONE;
               state_in      = ST_DONE;
               unique case (req_op)
                  OP_PUSH_REAR: begin
                     if (count_ff == CntFull) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  OP_POP_REAR: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        head_in  = slot_of(head_ff, CW'(1));
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     res_in.status = STAT_DONE;
                  end
               endcase
               res_in.count = count_out(count_in);
            end
         end
         ST_SCAN: begin
            priority if (pend_ff && (mem_rd_data == key_ff)) begin
               res_in.found = 1'b1;
               pend_in      = 1'b0;
               state_in     = ST_DONE;
            end else if (scan_ff < count_ff) begin
               mem_rd_en = 1'b1;
               scan_in   = scan_ff + CW'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

   `LSQS_ASSERT_ALWAYS(a_count_bound, count_ff <= CntFull, "entry count above depth")
   `LSQS_ASSERT_ALWAYS(a_head_bound, SW'(head_ff) < SW'(DEPTH), "head index out of range")
   `LSQS_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, state_ff != ST_IDLE, "accept left idle")
   `LSQS_ASSERT_ALWAYS(a_scan_bound, !(state_ff == ST_SCAN) || (scan_ff <= count_ff), "scan past count")

endmodule

### src/list_stack_queue_with_search_unit.sv
// ----------------------------------------------------------------------------
// list_stack_queue_with_search_unit
// Bounded deque of signed 32-bit words in a ring buffer with linear search.
//
// Input channel req_*: one command word per item. req_tuser carries the
// operation (push rear, pop rear, pop front, search), req_tdata the value to
// push or the key to search for. Result channel rsp_*: exactly one word per
// command with status (done, empty, full), found flag and the entry count
// after the command.
// Push and pop go straight to the done state on accept; the result then
// passes through the output register to rsp_tvalid. A search reads the
// store through its single read port, one entry a cycle, and compares with
// one comparator, ending early on a match. The sequencer takes no new
// command until the result of the last one has left it.
// A new command is taken once the previous result has moved into the output
// register; while rsp_tready is low the output register holds and the next
// result waits in the sequencer, which then accepts nothing.
// Reset empties the store at once (count and head cleared); no clearing pass.
// ----------------------------------------------------------------------------
`include "list_stack_queue_with_search_unit_macros.svh"

module list_stack_queue_with_search_unit #(
   parameter int unsigned DEPTH = lsqs_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] status, [2] found, [9:3] count
);
   import lsqs_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);

   logic               res_valid;
   logic               res_ready;
   res_type            res;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [VALUE_W-1:0] mem_wr_data;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   logic [VALUE_W-1:0] mem_rd_data;

   logic               rsp_valid_ff, rsp_valid_in;
   res_type            rsp_res_ff, rsp_res_in;

   lsqs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (op_type'(req_tuser)),
      .req_value   (req_tdata),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   lsqs_ram #(.DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_res_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_res_ff};

   `LSQS_ASSERT_NEXT(a_rsp_load, res_valid && res_ready, rsp_valid_ff, "result not loaded")
   `LSQS_ASSERT_ALWAYS(a_no_accept_busy, !(rsp_valid_ff && !rsp_tready && res_valid) || !req_tready, "accept while result blocked")

endmodule

### dv/deque_shadow_pkg.sv
// ----------------------------------------------------------------------------
// deque_shadow_pkg
// Shadow copy of the bounded deque with search. Each accepted command word
// updates the shadow and queues the result word it must produce; each result
// word from the block is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
package deque_shadow_pkg;

   import lsqs_pkg::*;

   class deque_shadow;
      logic [VALUE_W-1:0] slots [DEPTH_DEFAULT];
      int unsigned        head;
      int unsigned        held;
      res_type            awaited_q [$];
      int unsigned        fails;

      function new();
         head  = 0;
         held  = 0;
         fails = 0;
      endfunction

      function int unsigned size();
         return held;
      endfunction

      function logic [VALUE_W-1:0] entry(int unsigned k);
         return slots[(head + k) % DEPTH_DEFAULT];
      endfunction

      function int unsigned pending();
         return awaited_q.size();
      endfunction

      function void take_command(op_type op, logic [VALUE_W-1:0] value);
         res_type r;
         r.status = STAT_DONE;
         r.found  = 1'b0;
         case (op)
            OP_PUSH_REAR: begin
               if (held >= DEPTH_DEFAULT) begin
                  r.status = STAT_FULL;
               end else begin
                  slots[(head + held) % DEPTH_DEFAULT] = value;
                  held++;
               end
            end
            OP_POP_REAR: begin
               if (held == 0) r.status = STAT_EMPTY;
               else held--;
            end
            OP_POP_FRONT: begin
               if (held == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  head = (head + 1) % DEPTH_DEFAULT;
                  held--;
               end
            end
            OP_SEARCH: begin
               if (held == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  for (int unsigned k = 0; k < held; k++) begin
                     if (entry(k) == value) begin
                        r.found = 1'b1;
                        break;
                     end
                  end
               end
            end
         endcase
         r.count = COUNT_W'(held);
         awaited_q.push_back(r);
      endfunction

      function void check_word(logic [15:0] word);
         res_type want;
         res_type got;
         got = res_type'(word[$bits(res_type)-1:0]);
         if (awaited_q.size() == 0) begin
            $error("result word %h with no command outstanding", word);
            fails++;
            return;
         end
         want = awaited_q.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fails++;
         end
         if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            fails++;
         end
         if (got.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, got.count);
            fails++;
         end
      endfunction
   endclass

endpackage

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for list_stack_queue_with_search_unit. Directed commands cover the
// empty case and extreme values; random phases then fill to full, drain,
// mix and search the deque under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   import lsqs_pkg::*;
   import deque_shadow_pkg::*;

   localparam int unsigned ITEMS = 1050;
   localparam int unsigned LIMIT = 600000;
   localparam int unsigned TAIL  = DEPTH_DEFAULT + 16;

   typedef enum int {
      PH_FILL,
      PH_DRAIN,
      PH_MIX,
      PH_HUNT,
      PH_TOP_OFF,
      PH_EMPTY_OUT
   } phase_kind;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] value
   logic [1:0]  req_tuser  = '0;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [1:0] status, [2] found, [9:3] count

   deque_shadow        shadow = new();
   bit                 idling = 1'b0;
   int unsigned        sent   = 0;
   int unsigned        cycles = 0;
   logic [VALUE_W-1:0] recent [$];

   list_stack_queue_with_search_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) shadow.check_word(rsp_tdata);
   end

   initial begin
      forever begin
         @(posedge clock);
         if (idling && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_command(op_type op, logic [VALUE_W-1:0] value);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      shadow.take_command(op, value);
      sent++;
      if (op == OP_PUSH_REAR) begin
         recent.push_back(value);
         if (recent.size() > 32) void'(recent.pop_front());
      end
   endtask

   // hold off the sender until every word is back
   task automatic wait_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (shadow.pending() != 0);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         1: return $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_key();
      int unsigned n;
      n = shadow.size();
      case ($urandom_range(0, 4))
         0, 1: if (n > 0) return shadow.entry($urandom_range(0, n - 1));
         2: if (recent.size() > 0) return recent[$urandom_range(0, recent.size() - 1)];
         3: if (n > 0) return shadow.entry($urandom_range(0, n - 1)) ^
                              (32'd1 << $urandom_range(0, 31));
         default: ;
      endcase
      return pick_value();
   endfunction

   task automatic send_random(op_type op);
      send_command(op, (op == OP_SEARCH) ? pick_key() : pick_value());
   endtask

   function automatic op_type pick_pop();
      return ($urandom_range(0, 1) == 0) ? OP_POP_REAR : OP_POP_FRONT;
   endfunction

   task automatic run_phase(phase_kind kind);
      int unsigned n;
      int unsigned roll;
      case (kind)
         PH_TOP_OFF: begin
            while (shadow.size() < DEPTH_DEFAULT) begin
               if ($urandom_range(0, 5) == 0) send_random(OP_SEARCH);
               else send_random(OP_PUSH_REAR);
            end
            repeat ($urandom_range(1, 3)) send_random(OP_PUSH_REAR);
            repeat ($urandom_range(1, 4)) send_random(OP_SEARCH);
         end
         PH_EMPTY_OUT: begin
            while (shadow.size() > 0) begin
               if ($urandom_range(0, 5) == 0) send_random(OP_SEARCH);
               else send_random(pick_pop());
            end
            repeat ($urandom_range(1, 3)) send_random(pick_pop());
            send_random(OP_SEARCH);
         end
         default: begin
            n = $urandom_range(10, 60);
            repeat (n) begin
               roll = $urandom_range(0, 99);
               case (kind)
                  PH_FILL:  send_random(roll < 80 ? OP_PUSH_REAR :
                                        roll < 90 ? pick_pop() : OP_SEARCH);
                  PH_DRAIN: send_random(roll < 70 ? pick_pop() :
                                        roll < 80 ? OP_PUSH_REAR : OP_SEARCH);
                  PH_HUNT:  send_random(roll < 60 ? OP_SEARCH :
                                        op_type'($urandom_range(0, 3)));
                  default:  send_random(op_type'($urandom_range(0, 3)));
               endcase
            end
         end
      endcase
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_command(OP_SEARCH,    32'h0000_0000);
      send_command(OP_POP_REAR,  32'hffff_ffff);
      send_command(OP_POP_FRONT, 32'h0000_0000);
      send_command(OP_PUSH_REAR, 32'h8000_0000);
      send_command(OP_PUSH_REAR, 32'h7fff_ffff);
      send_command(OP_PUSH_REAR, 32'h0000_0000);
      send_command(OP_PUSH_REAR, 32'hffff_ffff);
      send_command(OP_SEARCH,    32'h7fff_ffff);
      send_command(OP_SEARCH,    32'h7fff_fffe);
      send_command(OP_SEARCH,    32'hffff_ffff);
      send_command(OP_SEARCH,    32'h8000_0000);
      send_command(OP_POP_FRONT, 32'h1234_5678);
      send_command(OP_SEARCH,    32'h8000_0000);
      send_command(OP_POP_REAR,  32'h0000_0000);
      send_command(OP_SEARCH,    32'hffff_ffff);
      send_command(OP_POP_REAR,  32'h0000_0000);
      send_command(OP_POP_REAR,  32'h0000_0000);
      send_command(OP_POP_FRONT, 32'h0000_0000);
      send_command(OP_PUSH_REAR, 32'h5a5a_a5a5);
      send_command(OP_POP_FRONT, 32'h0000_0000);
      send_command(OP_SEARCH,    32'h5a5a_a5a5);
      wait_results();

      while (sent < ITEMS) begin
         idling = (sent + 150 < ITEMS) && ($urandom_range(0, 3) != 0);
         run_phase(phase_kind'($urandom_range(0, 5)));
         if ($urandom_range(0, 5) == 0) wait_results();
      end
      idling = 1'b0;

      wait_results();
      repeat (TAIL) @(posedge clock);
      if (shadow.fails == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

### list_stack_queue_with_search_unit.f
+incdir+src
src/lsqs_pkg.sv
src/lsqs_ram.sv
src/lsqs_ctrl.sv
src/list_stack_queue_with_search_unit.sv
dv/deque_shadow_pkg.sv
dv/tb.sv
